@@ hdl/fwfm_pkg.sv @@
`default_nettype none

package fwfm_pkg;

    localparam int RULES_DEFAULT = 64;

    localparam int COUNT_W = 7;
    localparam int INDEX_W = 6;

    localparam logic OP_CLASSIFY = 1'b0;
    localparam logic OP_WRITE    = 1'b1;

    localparam logic [0:0] REG_RULE_COUNT = 1'b0;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_IGMP = 8'd2;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // one rule, or the header fields of one packet
    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  protocol;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic        check_extra;
        logic [2:0]  tcp_flags;
        logic [7:0]  icmp_type;
        logic [7:0]  icmp_code;
    } rule_t;

    // decoded word handed from front to back
    typedef struct packed {
        logic               is_write;
        logic               wr_ok;
        logic [INDEX_W-1:0] rule_index;
        rule_t              fields;
    } cmd_t;

    typedef struct packed {
        logic [1:0] q_count;
    } front_status_t;

    function automatic logic rule_match(rule_t r, rule_t p);
        logic base_ok;
        logic ports_ok;
        logic m;
        base_ok = (r.dst_addr == '0 || r.dst_addr == p.dst_addr)
               && (r.src_addr == '0 || r.src_addr == p.src_addr)
               && (r.protocol == '0 || r.protocol == p.protocol);
        ports_ok = (r.src_port == '0 || r.src_port == p.src_port)
                && (r.dst_port == '0 || r.dst_port == p.dst_port);
        case (p.protocol)
            PROTO_TCP:
                m = ports_ok && (!r.check_extra || r.tcp_flags == p.tcp_flags);
            PROTO_UDP:
                m = ports_ok;
            PROTO_ICMP, PROTO_IGMP:
                m = !r.check_extra
                    || (r.icmp_type == p.icmp_type && r.icmp_code == p.icmp_code);
            default:
                m = 1'b0;
        endcase
        return base_ok && m;
    endfunction

endpackage

`default_nettype wire

@@ hdl/firewall_rule_first_match_unit.sv @@
`default_nettype none

// First-match rule classifier. A word is taken when start is high and busy
// is low; each word gives one result on hit/hit_index, marked by a one-cycle
// done strobe that cannot be held off. A two-word queue parts the input from
// the search engine, so busy rises only when two words are waiting. A rule
// write is done by the engine straight from idle. A classify reads entry
// zero and then compares one rule at a time, up to the first match or the
// last entry in use, at most min(rule_count, RULES) rules; with rule_count
// zero it gives a miss without a search. The rule RAM has a single read
// port, which is why rules are compared one at a time. Rule entries are not
// cleared at reset and must be written before rule_count covers them.
module firewall_rule_first_match_unit #(
    parameter int RULES = fwfm_pkg::RULES_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        opcode,
    input  wire logic [5:0]  rule_index,
    input  wire logic [31:0] src_addr,
    input  wire logic [31:0] dst_addr,
    input  wire logic [7:0]  protocol,
    input  wire logic [15:0] src_port,
    input  wire logic [15:0] dst_port,
    input  wire logic        check_extra,
    input  wire logic [2:0]  tcp_flags,
    input  wire logic [7:0]  icmp_type,
    input  wire logic [7:0]  icmp_code,
    output logic             done,
    output logic             hit,
    output logic [5:0]       hit_index
);

    logic [fwfm_pkg::COUNT_W-1:0] rule_count_reg, rule_count_next;
    logic                         cfg_wr;
    fwfm_pkg::rule_t              fields;
    fwfm_pkg::cmd_t               q_cmd;
    fwfm_pkg::front_status_t      status;
    logic                         q_valid;
    logic                         pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2:2] == fwfm_pkg::REG_RULE_COUNT);

    assign rule_count_next = cfg_wr ? pwdata[fwfm_pkg::COUNT_W-1:0] : rule_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_count_reg <= '0;
        end
        else
        begin
            rule_count_reg <= rule_count_next;
        end
    end

    assign prdata = (paddr[2:2] == fwfm_pkg::REG_RULE_COUNT)
                    ? 32'(rule_count_reg) : 32'd0;

    always_comb
    begin
        fields.src_addr    = src_addr;
        fields.dst_addr    = dst_addr;
        fields.protocol    = protocol;
        fields.src_port    = src_port;
        fields.dst_port    = dst_port;
        fields.check_extra = check_extra;
        fields.tcp_flags   = tcp_flags;
        fields.icmp_type   = icmp_type;
        fields.icmp_code   = icmp_code;
    end

    fwfm_front #(
        .RULES(RULES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .rule_index(rule_index),
        .fields    (fields),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .status    (status)
    );

    fwfm_back #(
        .RULES(RULES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .rule_count(rule_count_reg),
        .done      (done),
        .hit       (hit),
        .hit_index (hit_index)
    );

`ifndef ASSERT_OFF
    // a hit comes only from the search state, which is entered from idle, so a hit never follows a result directly
    a_no_back_to_back_hit: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !(done && hit))
        else $error("hit result directly after another result");

    // a word taken always leaves the queue non-empty next cycle
    a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (status.q_count != 2'd0))
        else $error("accepted word lost from queue");

    a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (hit_index == 6'd0))
        else $error("miss result with non-zero index");
`endif

endmodule

`default_nettype wire

@@ hdl/fwfm_front.sv @@
`default_nettype none

module fwfm_front #(
    parameter int RULES = fwfm_pkg::RULES_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          opcode,
    input  wire logic [fwfm_pkg::INDEX_W-1:0]  rule_index,
    input  wire fwfm_pkg::rule_t               fields,
    input  wire logic                          pop,
    output logic                               q_valid,
    output fwfm_pkg::cmd_t                     q_cmd,
    output fwfm_pkg::front_status_t            status
);

    localparam int CMP_W = ($clog2(RULES + 1) > fwfm_pkg::INDEX_W)
                           ? $clog2(RULES + 1) : fwfm_pkg::INDEX_W;

    fwfm_pkg::cmd_t q_mem_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    fwfm_pkg::cmd_t cmd;
    logic           push;

    always_comb
    begin
        cmd.is_write   = (opcode == fwfm_pkg::OP_WRITE);
        // writes past the table are marked here and dropped by the back end
        cmd.wr_ok      = CMP_W'(rule_index) < CMP_W'(RULES);
        cmd.rule_index = rule_index;
        cmd.fields     = fields;
    end

    assign busy    = (count_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = q_mem_reg[rd_ptr_reg];
    assign status.q_count = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/fwfm_back.sv @@
`default_nettype none

module fwfm_back #(
    parameter int RULES = fwfm_pkg::RULES_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire fwfm_pkg::cmd_t                q_cmd,
    output logic                               pop,
    input  wire logic [fwfm_pkg::COUNT_W-1:0]  rule_count,
    output logic                               done,
    output logic                               hit,
    output logic [fwfm_pkg::INDEX_W-1:0]       hit_index
);

    localparam int AW = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int LW = ($clog2(RULES + 1) > fwfm_pkg::COUNT_W)
                        ? $clog2(RULES + 1) : fwfm_pkg::COUNT_W;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SEARCH = 2'b10
    } state_t;

    fwfm_pkg::rule_t mem [RULES];
    fwfm_pkg::rule_t rd_data_reg;
    logic [AW-1:0]   rd_addr;
    logic            mem_we;

    state_t                       state_reg, state_next;
    fwfm_pkg::rule_t              cur_reg, cur_next;
    logic [LW-1:0]                limit_reg, limit_next;
    logic [LW-1:0]                lim;
    logic [AW-1:0]                cmp_idx_reg, cmp_idx_next;
    logic                         done_reg, done_next;
    logic                         hit_reg, hit_next;
    logic [fwfm_pkg::INDEX_W-1:0] hit_index_reg, hit_index_next;

    assign lim = (LW'(rule_count) > LW'(RULES)) ? LW'(RULES) : LW'(rule_count);
    assign pop = (state_reg == ST_IDLE) && q_valid;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        limit_next     = limit_reg;
        cmp_idx_next   = cmp_idx_reg;
        done_next      = 1'b0;
        hit_next       = 1'b0;
        hit_index_next = '0;
        mem_we         = 1'b0;
        rd_addr        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.is_write)
                    begin
                        mem_we    = q_cmd.wr_ok;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        cur_next   = q_cmd.fields;
                        limit_next = lim;
                        if (lim == '0)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            // entry 0 is being read this cycle
                            cmp_idx_next = '0;
                            state_next   = ST_SEARCH;
                        end
                    end
                end
            end
            ST_SEARCH:
            begin
                rd_addr = cmp_idx_reg + AW'(1);
                if (fwfm_pkg::rule_match(rd_data_reg, cur_reg))
                begin
                    done_next      = 1'b1;
                    hit_next       = 1'b1;
                    hit_index_next = fwfm_pkg::INDEX_W'(cmp_idx_reg);
                    state_next     = ST_IDLE;
                end
                else if (LW'(cmp_idx_reg) + LW'(1) == limit_reg)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmp_idx_next = cmp_idx_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[AW'(q_cmd.rule_index)] <= q_cmd.fields;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        limit_reg   <= limit_next;
        cmp_idx_reg <= cmp_idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            hit_index_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            hit_reg       <= hit_next;
            hit_index_reg <= hit_index_next;
        end
    end

    assign done      = done_reg;
    assign hit       = hit_reg;
    assign hit_index = hit_index_reg;

endmodule

`default_nettype wire
